// ----- rtl/tkmr_pkg.sv -----
`timescale 1ns / 1ps

package tkmr_pkg;

  // Command codes
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_OFFER  = 2'd1,
    CMD_REPORT = 2'd2
  } cmd_e;

  localparam int unsigned IdW    = 23;
  localparam int unsigned PagesW = 40;
  localparam int unsigned NameW  = 64;
  localparam int unsigned KibW   = 51;
  localparam int unsigned RankW  = 3;
  localparam int unsigned ShiftW = 5;

  localparam logic [ShiftW-1:0] ShiftMin   = 5'd10;
  localparam logic [ShiftW-1:0] ShiftMax   = 5'd21;
  localparam logic [ShiftW-1:0] ShiftReset = 5'd12;

  // Register indexes
  localparam logic RegPageShift = 1'b0;

  // One table entry
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [PagesW-1:0] pages;
    logic [NameW-1:0]  name_lo;
    logic [NameW-1:0]  name_hi;
  } entry_t;

  // Per-cycle control shared by all cells
  typedef struct packed {
    logic clear;
    logic offer;
    logic rotate;
  } cell_ctrl_t;

  // Force byte 15 to zero and zero every byte after the first zero byte
  function automatic logic [2*NameW-1:0] tidy_name(input logic [NameW-1:0] lo,
                                                   input logic [NameW-1:0] hi);
    logic [2*NameW-1:0] w;
    logic               ended;
    w     = {hi, lo};
    w[2*NameW-1 -: 8] = 8'h00;
    ended = 1'b0;
    for (int b = 0; b < 16; b++) begin
      if (ended) begin
        w[b*8 +: 8] = 8'h00;
      end else if (w[b*8 +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return w;
  endfunction

endpackage

// ----- rtl/tkmr_cell.sv -----
`timescale 1ns / 1ps

module tkmr_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tkmr_pkg::cell_ctrl_t ctrl_i,
  input  tkmr_pkg::entry_t    new_i,
  input  tkmr_pkg::entry_t    prev_i,
  input  tkmr_pkg::entry_t    next_i,
  input  logic                gt_prev_i,
  output logic                gt_o,
  output tkmr_pkg::entry_t    entry_o
);

  tkmr_pkg::entry_t entry_d, entry_q;
  logic             gt;

  // Offer beats this slot
  assign gt = new_i.pages > entry_q.pages;

  // Pick the next slot content: clear it, shift down below the insert point, take
  // the offer at the insert point, rotate up during a report
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.clear) begin
      entry_d = '0;
    end else if (ctrl_i.offer) begin
      if (gt_prev_i) begin
        entry_d = prev_i;
      end else if (gt) begin
        entry_d = new_i;
      end
    end else if (ctrl_i.rotate) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign gt_o    = gt;
  assign entry_o = entry_q;

endmodule

// ----- rtl/top_k_memory_ranker.sv -----
`timescale 1ns / 1ps
// Clear and offer requests leave busy_o low, and the next request
// may follow in the next cycle. A report rotates the cell chain once around, past
// slot 0; each result is registered and appears in the cycle after its rotation
// step, one per occupied slot, and busy_o is high for the whole pass.
// Reset clears the table and sets the page-size shift to 12; the receiver cannot stall.
module top_k_memory_ranker #(
  parameter int unsigned TABLE_ENTRIES = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  cmd_i,
  input  logic [22:0] process_id_i,
  input  logic [39:0] resident_pages_i,
  input  logic [63:0] name_low_i,
  input  logic [63:0] name_high_i,
  input  logic        has_address_space_i,
  // results
  output logic        done_o,
  output logic [2:0]  rank_o,
  output logic [22:0] out_process_id_o,
  output logic [50:0] memory_kib_o,
  output logic [63:0] out_name_low_o,
  output logic [63:0] out_name_high_o,
  output logic        last_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned N    = TABLE_ENTRIES;
  localparam int unsigned CntW = (N > 1) ? $clog2(N) : 1;

  // ---------------- configuration ----------------
  logic [tkmr_pkg::ShiftW-1:0] log2_page_q;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == tkmr_pkg::RegPageShift);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_page_q <= tkmr_pkg::ShiftReset;
    end else if (cfg_wr) begin
      log2_page_q <= pwdata[tkmr_pkg::ShiftW-1:0];
    end
  end

  assign prdata = (paddr[2] == tkmr_pkg::RegPageShift)
                ? {{(32 - tkmr_pkg::ShiftW){1'b0}}, log2_page_q} : 32'd0;

  // ---------------- request decode ----------------
  logic                 busy_q;
  logic                 accept;
  logic                 do_clear, do_offer, do_report;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [N-1:0]         mask_q, mask_d, nz;
  logic [127:0]         tidy;
  tkmr_pkg::entry_t     offer_entry;
  tkmr_pkg::cell_ctrl_t ctrl;

  assign accept    = start_i && !busy_q;
  assign do_clear  = accept && (cmd_i == tkmr_pkg::CMD_CLEAR);
  assign do_offer  = accept && (cmd_i == tkmr_pkg::CMD_OFFER) && has_address_space_i;
  assign do_report = accept && (cmd_i == tkmr_pkg::CMD_REPORT);

  assign tidy                = tkmr_pkg::tidy_name(name_low_i, name_high_i);
  assign offer_entry.id      = process_id_i;
  assign offer_entry.pages   = resident_pages_i;
  assign offer_entry.name_lo = tidy[63:0];
  assign offer_entry.name_hi = tidy[127:64];

  assign ctrl.clear  = do_clear;
  assign ctrl.offer  = do_offer;
  assign ctrl.rotate = busy_q;

  // ---------------- cell chain ----------------
  tkmr_pkg::entry_t cells [N];
  logic [N-1:0]     gt;

  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam int unsigned Nxt = (i + 1) % N;
    tkmr_pkg::entry_t prev_e;
    logic             gt_prev;

    if (i == 0) begin : g_head
      assign prev_e  = '0;
      assign gt_prev = 1'b0;
    end else begin : g_body
      assign prev_e  = cells[i-1];
      assign gt_prev = gt[i-1];
    end

    tkmr_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .new_i     (offer_entry),
      .prev_i    (prev_e),
      .next_i    (cells[Nxt]),
      .gt_prev_i (gt_prev),
      .gt_o      (gt[i]),
      .entry_o   (cells[i])
    );

    assign nz[i] = cells[i].id != '0;
  end

  // ---------------- report sequencer ----------------
  always_comb begin
    cnt_d  = cnt_q;
    mask_d = mask_q;
    if (do_report) begin
      cnt_d  = '0;
      mask_d = nz;
    end else if (busy_q) begin
      cnt_d  = cnt_q + 1'b1;
      mask_d = mask_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      mask_q <= '0;
    end else begin
      if (do_report) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == CntW'(N - 1))) begin
        busy_q <= 1'b0;
      end
      cnt_q  <= (busy_q && (cnt_q == CntW'(N - 1))) ? '0 : cnt_d;
      mask_q <= mask_d;
    end
  end

  assign busy_o = busy_q;

  // ---------------- result registers ----------------
  logic [tkmr_pkg::ShiftW-1:0] ps_clamp;
  logic [3:0]                  sh;
  logic                        done_q;
  logic                        last_q;
  logic [2:0]                  rank_q;
  logic [22:0]                 id_q;
  logic [50:0]                 kib_q;
  logic [63:0]                 nlo_q, nhi_q;

  // Clamp page size to the supported range
  always_comb begin
    ps_clamp = log2_page_q;
    if (log2_page_q < tkmr_pkg::ShiftMin) begin
      ps_clamp = tkmr_pkg::ShiftMin;
    end else if (log2_page_q > tkmr_pkg::ShiftMax) begin
      ps_clamp = tkmr_pkg::ShiftMax;
    end
  end
  assign sh = 4'(ps_clamp - tkmr_pkg::ShiftMin);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      done_q <= busy_q && mask_q[0];
      last_q <= busy_q && mask_q[0] && ((mask_q >> 1) == '0);
    end
  end

  // Capture slot 0 as it passes
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rank_q <= 3'(cnt_q);
      id_q   <= cells[0].id;
      kib_q  <= 51'(cells[0].pages) << sh;
      nlo_q  <= cells[0].name_lo;
      nhi_q  <= cells[0].name_hi;
    end
  end

  assign done_o           = done_q;
  assign last_o           = last_q;
  assign rank_o           = rank_q;
  assign out_process_id_o = id_q;
  assign memory_kib_o     = kib_q;
  assign out_name_low_o   = nlo_q;
  assign out_name_high_o  = nhi_q;

  // ---------------- assertions ----------------
  a_done_from_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_q)) else $error("result outside a report pass");

  a_last_marks_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> done_o) else $error("last without result");

  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (cnt_q == '0)) else $error("counter not parked while idle");

  a_no_start_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !do_offer && !do_clear) else $error("table change during report");

  for (genvar k = 0; k + 1 < N; k++) begin : g_order
    a_descending: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !busy_q |-> (cells[k].pages >= cells[k+1].pages))
      else $error("table out of order");
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import tkmr_pkg::*;

  localparam int unsigned TableEntries = 5;
  localparam int unsigned SettleCycles = 2 * TableEntries + 4;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned PhaseItems   = 60;
  localparam logic [1:0]  CmdUnused    = 2'd3;
  localparam logic [2:0]  PageShiftAddr = 3'(4 * int'(RegPageShift));

  // Page shifts per random phase; the slot marked zero-based 4 is replaced at run time
  localparam logic [ShiftW-1:0] ShiftPlan [PhaseCount] =
    '{5'd10, 5'd21, 5'd0, 5'd31, 5'd12, 5'd16, 5'd11, 5'd20};

  typedef struct packed {
    logic [1:0]        cmd;
    logic [IdW-1:0]    id;
    logic [PagesW-1:0] pages;
    logic [NameW-1:0]  name_lo;
    logic [NameW-1:0]  name_hi;
    logic              has_mm;
  } ranker_request_t;

  typedef struct packed {
    logic [RankW-1:0] rank;
    logic [IdW-1:0]   id;
    logic [KibW-1:0]  kib;
    logic [NameW-1:0] name_lo;
    logic [NameW-1:0] name_hi;
    logic             last;
  } ranked_row_t;

  // Mirror of the ranking table plus the queue of rows that reports still owe
  class rank_table_model;
    entry_t            slots [TableEntries];
    logic [ShiftW-1:0] log2_page;
    ranked_row_t       expected_rows [$];
    int unsigned       mismatches;

    function new();
      foreach (slots[i]) slots[i] = '0;
      log2_page   = ShiftReset;
      mismatches  = 0;
    endfunction

    task report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Update the table for one accepted request, queue rows for a report
    function void apply_request(input ranker_request_t req);
      logic [2*NameW-1:0] name;
      logic               name_done;
      logic [ShiftW-1:0]  shift_amt;
      logic [63:0]        wide_kib;
      ranked_row_t        row;
      int                 first_row;
      case (req.cmd)
        CMD_CLEAR: begin
          foreach (slots[i]) slots[i] = '0;
        end
        CMD_OFFER: begin
          if (req.has_mm) begin
            // Byte 15 is always dropped; everything after the first NUL is zeroed
            name      = {8'h00, req.name_hi[NameW-9:0], req.name_lo};
            name_done = 1'b0;
            for (int k = 0; k < 16; k++) begin
              if (name_done) begin
                name[8*k +: 8] = 8'h00;
              end else if (name[8*k +: 8] == 8'h00) begin
                name_done = 1'b1;
              end
            end
            // Insert before the first strictly smaller slot, drop the bottom one
            for (int i = 0; i < TableEntries; i++) begin
              if (req.pages > slots[i].pages) begin
                for (int j = TableEntries - 1; j > i; j--) slots[j] = slots[j-1];
                slots[i].id      = req.id;
                slots[i].pages   = req.pages;
                slots[i].name_lo = name[NameW-1:0];
                slots[i].name_hi = name[2*NameW-1:NameW];
                break;
              end
            end
          end
        end
        CMD_REPORT: begin
          shift_amt = (log2_page < ShiftMin) ? ShiftMin :
                      (log2_page > ShiftMax) ? ShiftMax : log2_page;
          first_row = expected_rows.size();
          for (int i = 0; i < TableEntries; i++) begin
            if (slots[i].id != '0) begin
              wide_kib    = 64'(slots[i].pages) << (shift_amt - ShiftMin);
              row.rank    = RankW'(i);
              row.id      = slots[i].id;
              row.kib     = wide_kib[KibW-1:0];
              row.name_lo = slots[i].name_lo;
              row.name_hi = slots[i].name_hi;
              row.last    = 1'b0;
              expected_rows.push_back(row);
            end
          end
          if (expected_rows.size() > first_row) begin
            expected_rows[expected_rows.size()-1].last = 1'b1;
          end
        end
        default: begin
        end
      endcase
    endfunction

    // Compare one strobed row against the oldest owed row
    task check_reported(input ranked_row_t got);
      ranked_row_t want;
      if (expected_rows.size() == 0) begin
        report_mismatch($sformatf("row with nothing owed: rank %0d id %0h",
                                  got.rank, got.id));
        return;
      end
      want = expected_rows.pop_front();
      if (got.rank !== want.rank)
        report_mismatch($sformatf("rank %0d, want %0d", got.rank, want.rank));
      if (got.id !== want.id)
        report_mismatch($sformatf("id %0h, want %0h", got.id, want.id));
      if (got.kib !== want.kib)
        report_mismatch($sformatf("kib %0h, want %0h", got.kib, want.kib));
      if (got.name_lo !== want.name_lo)
        report_mismatch($sformatf("name_lo %h, want %h", got.name_lo, want.name_lo));
      if (got.name_hi !== want.name_hi)
        report_mismatch($sformatf("name_hi %h, want %h", got.name_hi, want.name_hi));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b at rank %0d",
                                  got.last, want.last, want.rank));
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [1:0]        cmd_i;
  logic [IdW-1:0]    process_id_i;
  logic [PagesW-1:0] resident_pages_i;
  logic [NameW-1:0]  name_low_i;
  logic [NameW-1:0]  name_high_i;
  logic              has_address_space_i;
  logic              done_o;
  logic [RankW-1:0]  rank_o;
  logic [IdW-1:0]    out_process_id_o;
  logic [KibW-1:0]   memory_kib_o;
  logic [NameW-1:0]  out_name_low_o;
  logic [NameW-1:0]  out_name_high_o;
  logic              last_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  rank_table_model ranker = new();

  top_k_memory_ranker #(
    .TABLE_ENTRIES(TableEntries)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .cmd_i              (cmd_i),
    .process_id_i       (process_id_i),
    .resident_pages_i   (resident_pages_i),
    .name_low_i         (name_low_i),
    .name_high_i        (name_high_i),
    .has_address_space_i(has_address_space_i),
    .done_o             (done_o),
    .rank_o             (rank_o),
    .out_process_id_o   (out_process_id_o),
    .memory_kib_o       (memory_kib_o),
    .out_name_low_o     (out_name_low_o),
    .out_name_high_o    (out_name_high_o),
    .last_o             (last_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #4 clk_i = ~clk_i;

  // Watch both handshakes at each edge: check rows first, then take the new request
  always @(posedge clk_i) begin : watch_ports
    ranked_row_t     seen_row;
    ranker_request_t seen_req;
    if (rst_ni) begin
      if (done_o) begin
        seen_row.rank    = rank_o;
        seen_row.id      = out_process_id_o;
        seen_row.kib     = memory_kib_o;
        seen_row.name_lo = out_name_low_o;
        seen_row.name_hi = out_name_high_o;
        seen_row.last    = last_o;
        ranker.check_reported(seen_row);
      end
      if (start_i && !busy_o) begin
        seen_req.cmd     = cmd_i;
        seen_req.id      = process_id_i;
        seen_req.pages   = resident_pages_i;
        seen_req.name_lo = name_low_i;
        seen_req.name_hi = name_high_i;
        seen_req.has_mm  = has_address_space_i;
        ranker.apply_request(seen_req);
      end
    end
  end

  // Present one request and hold it until the block takes it; start stays high
  task automatic send_request(input logic [1:0]        cmd,
                              input logic [IdW-1:0]    id,
                              input logic [PagesW-1:0] pages,
                              input logic [NameW-1:0]  name_lo,
                              input logic [NameW-1:0]  name_hi,
                              input logic              has_mm);
    start_i             <= 1'b1;
    cmd_i               <= cmd;
    process_id_i        <= id;
    resident_pages_i    <= pages;
    name_low_i          <= name_lo;
    name_high_i         <= name_hi;
    has_address_space_i <= has_mm;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic idle_for(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Write the page-size shift, then read it back
  task automatic set_log2_page(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PageShiftAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    ranker.log2_page = value[ShiftW-1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(value[ShiftW-1:0]))
      ranker.report_mismatch($sformatf("page shift reads %0h, want %0h",
                                       prdata, value[ShiftW-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drain every owed row, then give the block time to go quiet
  task automatic wait_quiet();
    while (ranker.expected_rows.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [1:0]        cmd;
    logic [IdW-1:0]    id;
    logic [PagesW-1:0] pages;
    logic [NameW-1:0]  name_lo;
    logic [NameW-1:0]  name_hi;
    logic              has_mm;
    logic [31:0]       wdata;
    int unsigned       pick;
    int unsigned       byte_sel;
    int unsigned       burst_left;

    // Hold every input at a known value through reset
    rst_ni              <= 1'b0;
    start_i             <= 1'b0;
    cmd_i               <= CMD_CLEAR;
    process_id_i        <= '0;
    resident_pages_i    <= '0;
    name_low_i          <= '0;
    name_high_i         <= '0;
    has_address_space_i <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: empty table, ignored offers, extremes, ties, overflow, id zero
    send_request(CMD_REPORT, 23'd1, 40'd1, '0, '0, 1'b1);
    send_request(CMD_OFFER, 23'd5, 40'd1000, 64'h0041_4243, '0, 1'b0);
    send_request(CMD_REPORT, '0, '0, '0, '0, 1'b0);
    send_request(CmdUnused, 23'd6, 40'd2000, '1, '1, 1'b1);
    send_request(CMD_OFFER, '1, '1, '1, '1, 1'b1);
    send_request(CMD_OFFER, 23'd4194304, 40'd0, 64'h6867_6665_6463_6261, '0, 1'b1);
    send_request(CMD_OFFER, 23'd0, 40'd500, 64'h6665_6400_6362_6160, '1, 1'b1);
    send_request(CMD_OFFER, 23'd7, 40'd500, 64'h3837_3635_3433_3231,
                 64'h4847_4645_0043_4241, 1'b1);
    idle_for(3);
    send_request(CMD_OFFER, 23'd9, 40'd500, {$urandom, $urandom}, {$urandom, $urandom},
                 1'b1);
    send_request(CMD_OFFER, 23'd11, 40'd1, '0, '0, 1'b1);
    send_request(CMD_OFFER, 23'd12, 40'd600, 64'h00FF_FFFF_FFFF_FFFF, '1, 1'b1);
    send_request(CMD_REPORT, '1, '1, '1, '1, 1'b1);
    send_request(CMD_OFFER, 23'd13, 40'd2, '1, '0, 1'b1);
    send_request(CMD_REPORT, '0, '0, '0, '0, 1'b0);
    idle_for(2);
    send_request(CMD_CLEAR, '1, '1, '1, '1, 1'b1);
    send_request(CMD_REPORT, '0, '0, '0, '0, 1'b0);
    send_request(CMD_OFFER, 23'd1, 40'd1, 64'h0000_0000_0000_0078, '0, 1'b1);
    send_request(CMD_REPORT, '0, '0, '0, '0, 1'b0);
    send_request(CMD_CLEAR, '0, '0, '0, '0, 1'b0);
    send_request(CMD_OFFER, 23'd0, 40'd3, '1, '1, 1'b1);
    send_request(CMD_REPORT, '0, '0, '0, '0, 1'b0);

    // Random phases, each under its own page size
    burst_left = 0;
    for (int p = 0; p < PhaseCount; p++) begin
      start_i <= 1'b0;
      wait_quiet();
      wdata = $urandom;
      if ($urandom_range(0, 1) != 0) wdata[31:ShiftW] = '0;
      wdata[ShiftW-1:0] = (p == 4) ? ShiftW'($urandom_range(0, 31)) : ShiftPlan[p];
      set_log2_page(wdata);
      if (p == 0) begin
        // Offer a fresh table to the first phase
        send_request(CMD_CLEAR, '0, '0, '0, '0, 1'b0);
      end

      for (int n = 0; n < PhaseItems; n++) begin
        // Work in bursts; some bursts follow the last one with no gap
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 7));
        end
        burst_left--;

        pick = $urandom_range(0, 99);
        if (pick < 3)       cmd = CMD_CLEAR;
        else if (pick < 76) cmd = CMD_OFFER;
        else if (pick < 94) cmd = CMD_REPORT;
        else                cmd = CmdUnused;

        pick = $urandom_range(0, 9);
        if (pick == 0)      id = '0;
        else if (pick == 1) id = IdW'($urandom);
        else                id = IdW'($urandom_range(1, 4194304));

        // Mostly small counts so ties and mid-table inserts are common
        pick = $urandom_range(0, 9);
        if (pick <= 5)      pages = PagesW'($urandom_range(0, 24));
        else if (pick <= 7) pages = PagesW'({$urandom, $urandom});
        else if (pick == 8) pages = '1;
        else                pages = PagesW'($urandom_range(0, 4096));

        name_lo = {$urandom, $urandom};
        name_hi = {$urandom, $urandom};
        if ($urandom_range(0, 2) == 0) begin
          byte_sel = $urandom_range(0, 15);
          if (byte_sel < 8) name_lo[8*byte_sel +: 8] = 8'h00;
          else              name_hi[8*(byte_sel-8) +: 8] = 8'h00;
        end
        has_mm = ($urandom_range(0, 7) != 0);

        send_request(cmd, id, pages, name_lo, name_hi, has_mm);
      end
    end

    start_i <= 1'b0;
    wait_quiet();
    if (ranker.expected_rows.size() != 0)
      ranker.report_mismatch($sformatf("%0d rows never reported",
                                       ranker.expected_rows.size()));
    if (ranker.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tkmr_pkg.sv
rtl/tkmr_cell.sv
rtl/top_k_memory_ranker.sv
verif/testbench.sv
